@@ hdl/sh24_pkg.sv @@
// ----------------------------------------------------------------------------
// sh24_pkg
// Shared types, constants and round functions for the SipHash-2-4 stream unit.
// ----------------------------------------------------------------------------
package sh24_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned TDATA_W = 72;   // word + byte count, padded to bytes
    localparam int unsigned STEP_W  = 3;

    localparam logic [WORD_W-1:0] INIT_C0   = 64'h736f_6d65_7073_6575;
    localparam logic [WORD_W-1:0] INIT_C1   = 64'h646f_7261_6e64_6f6d;
    localparam logic [WORD_W-1:0] INIT_C2   = 64'h6c79_6765_6e65_7261;
    localparam logic [WORD_W-1:0] INIT_C3   = 64'h7465_6462_7974_6573;
    localparam logic [WORD_W-1:0] FINAL_XOR = 64'h0000_0000_0000_00ff;

    localparam logic [CNT_W-1:0] FULL_COUNT  = 4'd8;
    localparam logic [LEN_W-1:0] WORD_BYTES  = 8'd8;
    localparam int unsigned      LEN_SHIFT   = 56;

    localparam int unsigned ROT_A = 13;
    localparam int unsigned ROT_B = 16;
    localparam int unsigned ROT_C = 32;
    localparam int unsigned ROT_D = 17;
    localparam int unsigned ROT_E = 21;

    // Rounds already done when the closing round of each phase runs
    localparam logic [STEP_W-1:0] STEP_ABSORB_END = 3'd1;
    localparam logic [STEP_W-1:0] STEP_BLOCK_END  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SHORT_DONE = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FULL_DONE  = 3'd7;

    // APB register map, one 64-bit register per 8 bytes
    localparam int unsigned ADDR_W   = 4;
    localparam logic        REG_KEY_LOW  = 1'b0;
    localparam logic        REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } lanes_t;

    typedef struct packed {
        logic start;      // word accepted: init/xor, first round
        logic round_en;   // run one round on the lanes
        logic xor_v0;     // close an absorb
        logic xor_v2;     // open finalization
        logic xor_v3;     // open the absorb of the final block
        logic load_hash;  // capture the folded lanes
    } cmd_t;

    typedef struct packed {
        logic count_full; // incoming word carries eight valid bytes, or a byte count above eight
    } status_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned s);
        rotl = (x << s) | (x >> (WORD_W - s));
    endfunction

    function automatic lanes_t sip_round(input lanes_t l);
        lanes_t r;
        r = l;
        r.v0 = r.v0 + r.v1;
        r.v2 = r.v2 + r.v3;
        r.v1 = rotl(r.v1, ROT_A) ^ r.v0;
        r.v3 = rotl(r.v3, ROT_B) ^ r.v2;
        r.v0 = rotl(r.v0, ROT_C);
        r.v2 = r.v2 + r.v1;
        r.v0 = r.v0 + r.v3;
        r.v1 = rotl(r.v1, ROT_D) ^ r.v2;
        r.v3 = rotl(r.v3, ROT_E) ^ r.v0;
        r.v2 = rotl(r.v2, ROT_C);
        return r;
    endfunction

    // Keep the low 'n' bytes of a word, n in 0..7
    function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] n);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < n) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

@@ hdl/sh24_ctrl.sv @@
// ----------------------------------------------------------------------------
// sh24_ctrl
// Round sequencer: schedules SipRounds and lane xors, owns both handshakes.
// ----------------------------------------------------------------------------
module sh24_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sh24_pkg::status_t sts,
    output sh24_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [sh24_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          last_reg, last_next;
    logic                          full_reg, full_next;
    logic                          valid_reg, valid_next;
    logic                          accept;
    logic                          emit_round;
    logic                          done;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        full_next  = full_reg;
        cmd        = '0;
        emit_round = 1'b0;
        done       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.start  = 1'b1;
                    step_next  = sh24_pkg::STEP_W'(1);
                    last_next  = s_tlast;
                    full_next  = sts.count_full;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!last_reg) begin
                    cmd.xor_v0 = (step_reg == sh24_pkg::STEP_ABSORB_END);
                    done       = (step_reg == sh24_pkg::STEP_ABSORB_END);
                end else if (full_reg) begin
                    cmd.xor_v0 = (step_reg == sh24_pkg::STEP_ABSORB_END) ||
                                 (step_reg == sh24_pkg::STEP_BLOCK_END);
                    cmd.xor_v3 = (step_reg == sh24_pkg::STEP_ABSORB_END);
                    cmd.xor_v2 = (step_reg == sh24_pkg::STEP_BLOCK_END);
                    emit_round = (step_reg == sh24_pkg::STEP_FULL_DONE);
                end else begin
                    cmd.xor_v0 = (step_reg == sh24_pkg::STEP_ABSORB_END);
                    cmd.xor_v2 = (step_reg == sh24_pkg::STEP_ABSORB_END);
                    emit_round = (step_reg == sh24_pkg::STEP_SHORT_DONE);
                end

                // hold the final round while the previous hash is still waiting
                if (emit_round && valid_reg && !m_tready) begin
                    cmd = '0;
                end else begin
                    cmd.round_en  = 1'b1;
                    cmd.load_hash = emit_round;
                    step_next     = step_reg + sh24_pkg::STEP_W'(1);
                    if (done || emit_round) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (cmd.load_hash) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            last_reg  <= 1'b0;
            full_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            full_reg  <= full_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ hdl/sh24_datapath.sv @@
// ----------------------------------------------------------------------------
// sh24_datapath
// Lane registers, one SipRound unit, block builder, length counter, hash hold.
// ----------------------------------------------------------------------------
module sh24_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sh24_pkg::cmd_t                cmd,
    output sh24_pkg::status_t             sts,
    input  logic [sh24_pkg::WORD_W-1:0]   key_low,
    input  logic [sh24_pkg::WORD_W-1:0]   key_high,
    input  logic [sh24_pkg::WORD_W-1:0]   message_word,
    input  logic [sh24_pkg::CNT_W-1:0]    byte_count,
    input  logic                          last_word,
    output logic [sh24_pkg::WORD_W-1:0]   hash_value
);

    sh24_pkg::lanes_t              lanes_reg, lanes_next;
    logic [sh24_pkg::WORD_W-1:0]   msg_reg, msg_next;
    logic [sh24_pkg::WORD_W-1:0]   blk_reg, blk_next;
    logic [sh24_pkg::WORD_W-1:0]   hash_reg, hash_next;
    logic [sh24_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                          open_reg, open_next;

    logic [sh24_pkg::CNT_W-1:0]    cnt_sat;
    logic [sh24_pkg::LEN_W-1:0]    len_base;
    logic [sh24_pkg::LEN_W-1:0]    len_total;
    logic [sh24_pkg::WORD_W-1:0]   len_word;
    logic [sh24_pkg::WORD_W-1:0]   first_m;
    logic [sh24_pkg::WORD_W-1:0]   tail_blk;
    sh24_pkg::lanes_t              init_lanes;
    sh24_pkg::lanes_t              round_in;
    sh24_pkg::lanes_t              round_out;
    sh24_pkg::lanes_t              post;

    assign hash_value = hash_reg;

    always_comb begin
        cnt_sat = (byte_count > sh24_pkg::FULL_COUNT) ? sh24_pkg::FULL_COUNT : byte_count;
        sts.count_full = (cnt_sat == sh24_pkg::FULL_COUNT);

        len_base  = open_reg ? len_reg : '0;
        len_total = len_base + sh24_pkg::LEN_W'(cnt_sat);
        len_word  = sh24_pkg::WORD_W'(len_total) << sh24_pkg::LEN_SHIFT;
        tail_blk  = (message_word & sh24_pkg::byte_mask(cnt_sat[2:0])) | len_word;

        // a full last word is absorbed first; the length then rides alone
        if (last_word && !sts.count_full) begin
            first_m = tail_blk;
        end else begin
            first_m = message_word;
        end

        init_lanes.v0 = key_low  ^ sh24_pkg::INIT_C0;
        init_lanes.v1 = key_high ^ sh24_pkg::INIT_C1;
        init_lanes.v2 = key_low  ^ sh24_pkg::INIT_C2;
        init_lanes.v3 = key_high ^ sh24_pkg::INIT_C3;

        round_in = lanes_reg;
        if (cmd.start) begin
            round_in    = open_reg ? lanes_reg : init_lanes;
            round_in.v3 = round_in.v3 ^ first_m;
        end
        round_out = sh24_pkg::sip_round(round_in);

        post = round_out;
        if (cmd.xor_v0) post.v0 = post.v0 ^ msg_reg;
        if (cmd.xor_v2) post.v2 = post.v2 ^ sh24_pkg::FINAL_XOR;
        if (cmd.xor_v3) post.v3 = post.v3 ^ blk_reg;

        lanes_next = (cmd.start || cmd.round_en) ? post : lanes_reg;

        msg_next = msg_reg;
        blk_next = blk_reg;
        if (cmd.start) begin
            msg_next = first_m;
            blk_next = len_word;
        end else if (cmd.xor_v3) begin
            msg_next = blk_reg;
        end

        len_next  = len_reg;
        open_next = open_reg;
        if (cmd.start) begin
            len_next  = last_word ? '0 : (len_base + sh24_pkg::WORD_BYTES);
            open_next = !last_word;
        end

        hash_next = hash_reg;
        if (cmd.load_hash) begin
            hash_next = post.v0 ^ post.v1 ^ post.v2 ^ post.v3;
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
        msg_reg   <= msg_next;
        blk_reg   <= blk_next;
        hash_reg  <= hash_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            open_reg <= 1'b0;
        end else begin
            len_reg  <= len_next;
            open_reg <= open_next;
        end
    end

endmodule

@@ hdl/siphash_2_4_stream_unit.sv @@
// ----------------------------------------------------------------------------
// siphash_2_4_stream_unit
// Keyed SipHash-2-4 over a stream of 64-bit little-endian message words.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake         payload
//  s_*       in         s_tvalid/s_tready s_tdata = message_word, byte_count;
//                                          s_tlast = last_word
//  m_*       out        m_tvalid/m_tready m_tdata = hash_value
//  apb       in         psel/penable      key_low at 0x0, key_high at 0x8
//
//  One SipRound unit, one round per cycle while no final round is held. A non-last
//  word runs 2 rounds, a last word with 0..7 bytes runs 6, a last word with 8 runs 8.
//  The first round runs in the cycle the word is taken; s_tready rises
//  again once the word's rounds are done.
//  A finished hash sits in an output register; new words are taken while it
//  waits, and only the final round of the next message holds until it leaves.
//  aresetn is synchronous, active low: it clears the keys, the length
//  counter, the open-message flag and the sequencer. No clearing pass.
//
module siphash_2_4_stream_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] message_word, [67:64] byte_count, [71:68] zero
    input  logic        s_tlast,   // last_word

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] hash_value

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [sh24_pkg::WORD_W-1:0] key_low_reg,  key_low_next;
    logic [sh24_pkg::WORD_W-1:0] key_high_reg, key_high_next;
    logic                        cfg_write;
    sh24_pkg::cmd_t              cmd;
    sh24_pkg::status_t           sts;

    // APB: zero wait states, paddr[3] picks the 64-bit key register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_write) begin
            case (paddr[3])
                sh24_pkg::REG_KEY_LOW:  key_low_next  = pwdata;
                sh24_pkg::REG_KEY_HIGH: key_high_next = pwdata;
                default: begin
                    key_low_next = key_low_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            sh24_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            sh24_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

    // Sequencer: one word at a time, rounds counted out per word kind
    sh24_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Lanes, round unit and hash register; the key is sampled at message start
    sh24_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .key_low      (key_low_reg),
        .key_high     (key_high_reg),
        .message_word (s_tdata[63:0]),
        .byte_count   (s_tdata[67:64]),
        .last_word    (s_tlast),
        .hash_value   (m_tdata)
    );

endmodule
